[design/glos_pkg.sv]
// ----------------------------------------------------------------------------
// glos_pkg
// shared types and constants for the grid line-of-sight checker
// ----------------------------------------------------------------------------
package glos_pkg;

  // default grid limits
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // coordinate and register widths
  localparam int COORD_W = 8;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;
  // bresenham error term, holds twice the largest span plus sign
  localparam int ERR_W   = 11;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAP_PRESENT = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RST_GRID_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_GRID_HEIGHT = 9'd256;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_WALK,
    S_SIDE_A,
    S_SIDE_B,
    S_DRAIN,
    S_FIN
  } state_t;

endpackage

[design/glos_map.sv]
// ----------------------------------------------------------------------------
// glos_map
// one-bit occupancy memory, cell (x, y) at y * MAX_WIDTH + x,
// one write port and one registered read port
// ----------------------------------------------------------------------------
module glos_map #(
  parameter int MAX_WIDTH  = glos_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = glos_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [glos_pkg::COORD_W-1:0] wr_x,
  input  logic [glos_pkg::COORD_W-1:0] wr_y,
  input  logic                         wr_bit,
  input  logic                         rd_en,
  input  logic [glos_pkg::COORD_W-1:0] rd_x,
  input  logic [glos_pkg::COORD_W-1:0] rd_y,
  output logic                         rd_bit
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic          occ_r [DEPTH];
  logic          rd_bit_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // callers only enable a port for cells inside the grid
  assign wr_addr = AW'(AW'(wr_y) * AW'(MAX_WIDTH)) + AW'(wr_x);
  assign rd_addr = AW'(AW'(rd_y) * AW'(MAX_WIDTH)) + AW'(rd_x);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      occ_r[wr_addr] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit_r <= occ_r[rd_addr];
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

[design/grid_line_of_sight_check.sv]
// ----------------------------------------------------------------------------
// grid_line_of_sight_check
// occupancy grid with a supercover bresenham line-of-sight query
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//  in      | in        | in_valid/in_ready  | req_type, from/to x/y, occupied
//  out     | out       | out_valid/out_ready| line_free
//
//  a write goes straight to the finishing state; a query checks each cell
//  of the line, the stepped cell and both side cells of a diagonal step,
//  with one map read per checked cell inside the grid
//  the single map read port sets the query time; an occupied cell ends it
//  early. reset is synchronous and clears control and config, not the map
//  a finished result waits in the output register while the next item is
//  taken; only the final handoff stalls on out_ready
// ----------------------------------------------------------------------------
module grid_line_of_sight_check #(
  parameter int MAX_WIDTH  = glos_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = glos_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [glos_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]    cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [glos_pkg::COORD_W-1:0]  in_from_x,
  input  logic [glos_pkg::COORD_W-1:0]  in_from_y,
  input  logic [glos_pkg::COORD_W-1:0]  in_to_x,
  input  logic [glos_pkg::COORD_W-1:0]  in_to_y,
  input  logic                          in_occupied,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_line_free
);

  localparam int CRDW = glos_pkg::COORD_W;
  localparam int EW   = glos_pkg::ERR_W;
  // compare width wide enough for the grid registers and the limits
  localparam int CWX = ($clog2(MAX_WIDTH + 1) > glos_pkg::CFG_W) ?
                       $clog2(MAX_WIDTH + 1) : glos_pkg::CFG_W;
  localparam int CWY = ($clog2(MAX_HEIGHT + 1) > glos_pkg::CFG_W) ?
                       $clog2(MAX_HEIGHT + 1) : glos_pkg::CFG_W;

  // configuration registers
  logic [glos_pkg::CFG_W-1:0] grid_w_r;
  logic [glos_pkg::CFG_W-1:0] grid_h_r;
  logic                       map_on_r;

  // sequencer
  glos_pkg::state_t state_r, state_nxt;

  // walk datapath
  logic [CRDW-1:0]        cx_r, cx_nxt;      // current cell
  logic [CRDW-1:0]        cy_r, cy_nxt;
  logic [CRDW-1:0]        px_r, px_nxt;      // cell before the last step
  logic [CRDW-1:0]        py_r, py_nxt;
  logic [CRDW-1:0]        tx_r, tx_nxt;      // end cell
  logic [CRDW-1:0]        ty_r, ty_nxt;
  logic [CRDW-1:0]        dx_r, dx_nxt;
  logic [CRDW-1:0]        dy_r, dy_nxt;
  logic                   sx_r, sx_nxt;      // 1 steps up, 0 steps down
  logic                   sy_r, sy_nxt;
  logic signed [EW-1:0]   err_r, err_nxt;
  logic                   res_r, res_nxt;

  // check pipeline: one cell issued per cycle, judged in the next cycle
  logic                   chk_vld_r, chk_vld_nxt;
  logic                   chk_out_r, chk_out_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_free_r, out_free_nxt;

  // combinational
  logic                   accept;
  logic                   slot_free;
  logic                   blocked_now;
  logic                   at_end;
  logic signed [EW-1:0]   e2;
  logic signed [EW-1:0]   dx_s;
  logic signed [EW-1:0]   dy_s;
  logic                   step_x;
  logic                   step_y;
  logic [CRDW-1:0]        nx;
  logic [CRDW-1:0]        ny;
  logic signed [EW-1:0]   err_step;
  logic [CRDW-1:0]        in_dx;
  logic [CRDW-1:0]        in_dy;
  logic                   issue_en;
  logic [CRDW-1:0]        issue_x;
  logic [CRDW-1:0]        issue_y;
  logic                   issue_in;
  logic                   wr_en;
  logic                   rd_bit;

  // inside the configured grid and the memory limits
  function automatic logic cell_in(input logic [CRDW-1:0] x, input logic [CRDW-1:0] y,
                                   input logic [glos_pkg::CFG_W-1:0] gw,
                                   input logic [glos_pkg::CFG_W-1:0] gh);
    logic ok;
    ok = (CWX'(x) < CWX'(gw)) && (CWX'(x) < CWX'(MAX_WIDTH)) &&
         (CWY'(y) < CWY'(gh)) && (CWY'(y) < CWY'(MAX_HEIGHT));
    return ok;
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= glos_pkg::RST_GRID_WIDTH;
      grid_h_r <= glos_pkg::RST_GRID_HEIGHT;
      map_on_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        glos_pkg::CFG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
        glos_pkg::CFG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
        glos_pkg::CFG_MAP_PRESENT: map_on_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- step math
  assign accept      = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  // a cell issued last cycle that lies outside, or reads back occupied
  assign blocked_now = chk_vld_r && (chk_out_r || rd_bit);
  assign at_end      = (cx_r == tx_r) && (cy_r == ty_r);

  assign dx_s     = EW'($signed({1'b0, dx_r}));
  assign dy_s     = EW'($signed({1'b0, dy_r}));
  assign e2       = err_r <<< 1;
  assign step_x   = e2 > -dy_s;
  assign step_y   = e2 < dx_s;
  assign nx       = step_x ? (sx_r ? cx_r + CRDW'(1) : cx_r - CRDW'(1)) : cx_r;
  assign ny       = step_y ? (sy_r ? cy_r + CRDW'(1) : cy_r - CRDW'(1)) : cy_r;
  assign err_step = err_r - (step_x ? dy_s : EW'(0)) + (step_y ? dx_s : EW'(0));

  assign in_dx = (in_to_x > in_from_x) ? in_to_x - in_from_x : in_from_x - in_to_x;
  assign in_dy = (in_to_y > in_from_y) ? in_to_y - in_from_y : in_from_y - in_to_y;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      glos_pkg::S_IDLE: begin
        if (accept) begin
          if (in_req_type == glos_pkg::REQ_QUERY && map_on_r) begin
            state_nxt = glos_pkg::S_FIRST;
          end else begin
            state_nxt = glos_pkg::S_FIN;
          end
        end
      end
      glos_pkg::S_FIRST: state_nxt = glos_pkg::S_WALK;
      glos_pkg::S_WALK: begin
        if (blocked_now) begin
          state_nxt = glos_pkg::S_FIN;
        end else if (at_end) begin
          state_nxt = glos_pkg::S_DRAIN;
        end else if (step_x && step_y) begin
          state_nxt = glos_pkg::S_SIDE_A;
        end
      end
      glos_pkg::S_SIDE_A: begin
        state_nxt = blocked_now ? glos_pkg::S_FIN : glos_pkg::S_SIDE_B;
      end
      glos_pkg::S_SIDE_B: begin
        state_nxt = blocked_now ? glos_pkg::S_FIN : glos_pkg::S_WALK;
      end
      glos_pkg::S_DRAIN: state_nxt = glos_pkg::S_FIN;
      glos_pkg::S_FIN: begin
        if (slot_free) begin
          state_nxt = glos_pkg::S_IDLE;
        end
      end
      default: state_nxt = glos_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- state outputs
  always_comb begin
    in_ready = 1'b0;
    issue_en = 1'b0;
    issue_x  = cx_r;
    issue_y  = cy_r;
    case (state_r)
      glos_pkg::S_IDLE: in_ready = 1'b1;
      // start cell
      glos_pkg::S_FIRST: issue_en = 1'b1;
      // stepped cell, checked before its side cells
      glos_pkg::S_WALK: begin
        issue_en = !blocked_now && !at_end;
        issue_x  = nx;
        issue_y  = ny;
      end
      // side cells of a diagonal step
      glos_pkg::S_SIDE_A: begin
        issue_en = !blocked_now;
        issue_y  = py_r;
      end
      glos_pkg::S_SIDE_B: begin
        issue_en = !blocked_now;
        issue_x  = px_r;
      end
      default: ;
    endcase
  end

  assign issue_in = cell_in(issue_x, issue_y, grid_w_r, grid_h_r);
  assign wr_en    = accept && (in_req_type == glos_pkg::REQ_WRITE) &&
                    cell_in(in_from_x, in_from_y, grid_w_r, grid_h_r);

  // ---------------------------------------------------------------- datapath
  always_comb begin
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    tx_nxt  = tx_r;
    ty_nxt  = ty_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    err_nxt = err_r;
    res_nxt = res_r;
    if (accept) begin
      cx_nxt  = in_from_x;
      cy_nxt  = in_from_y;
      tx_nxt  = in_to_x;
      ty_nxt  = in_to_y;
      dx_nxt  = in_dx;
      dy_nxt  = in_dy;
      sx_nxt  = in_from_x < in_to_x;
      sy_nxt  = in_from_y < in_to_y;
      err_nxt = EW'($signed({1'b0, in_dx})) - EW'($signed({1'b0, in_dy}));
      // writes and queries without a map answer 0
      res_nxt = 1'b0;
    end else if (state_r == glos_pkg::S_WALK && issue_en) begin
      cx_nxt  = nx;
      cy_nxt  = ny;
      px_nxt  = cx_r;
      py_nxt  = cy_r;
      err_nxt = err_step;
    end else if (state_r == glos_pkg::S_DRAIN) begin
      res_nxt = !blocked_now;
    end
  end

  assign chk_vld_nxt = issue_en;
  assign chk_out_nxt = !issue_in;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_free_nxt  = out_free_r;
    if (state_r == glos_pkg::S_FIN && slot_free) begin
      out_valid_nxt = 1'b1;
      out_free_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glos_pkg::S_IDLE;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    err_r      <= err_nxt;
    res_r      <= res_nxt;
    chk_out_r  <= chk_out_nxt;
    out_free_r <= out_free_nxt;
  end

  // ---------------------------------------------------------------- map memory
  // the map only changes in idle, so a query never reads a cell in flight
  glos_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_x   (in_from_x),
    .wr_y   (in_from_y),
    .wr_bit (in_occupied),
    .rd_en  (issue_en && issue_in),
    .rd_x   (issue_x),
    .rd_y   (issue_y),
    .rd_bit (rd_bit)
  );

  assign out_valid     = out_valid_r;
  assign out_line_free = out_free_r;

endmodule

[design/glos_chk.sv]
// ----------------------------------------------------------------------------
// glos_chk
// port-level checks for the grid line-of-sight checker, bound to the top
// ----------------------------------------------------------------------------
module glos_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_free
);

  // one item at a time: a transfer always makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("glos_chk: in_ready held after an input transfer");

  // a result is only produced while no item can be taken
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("glos_chk: result appeared while idle");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_free))
    else $error("glos_chk: stalled result changed");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("glos_chk: result pending after reset");

endmodule

bind grid_line_of_sight_check glos_chk u_glos_chk (.*);
